// File: hw/rtl/wait_graph_cycle_finder_core_macros.svh
// Assertion shorthands used by the checker of the cycle finder.
`ifndef WAIT_GRAPH_CYCLE_FINDER_CORE_MACROS_SVH
`define WAIT_GRAPH_CYCLE_FINDER_CORE_MACROS_SVH
// Consequent checked in the same cycle as the antecedent.
`define WGCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define WGCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hw/rtl/wgcf_pkg.sv
`default_nettype none
package wgcf_pkg;

	localparam int NODE_W = 7;
	localparam int SLOT_W = 18;
	localparam int EPOCH_W = 64;
	localparam int REQ_W = 64;
	localparam int CFG_W = 7;
	localparam int TOTAL_W = 7;
	localparam int RESULT_CAP = 64;
	localparam int EMW = 7;
	localparam int EIW = 6;
	localparam int OP_W = 5;

	localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
	localparam logic [OP_W-1:0] OP_LK_RD   = 5'd1;
	localparam logic [OP_W-1:0] OP_LK_CMP  = 5'd2;
	localparam logic [OP_W-1:0] OP_ADD_W   = 5'd3;
	localparam logic [OP_W-1:0] OP_ADD_B   = 5'd4;
	localparam logic [OP_W-1:0] OP_ED_WR   = 5'd5;
	localparam logic [OP_W-1:0] OP_S_INIT  = 5'd6;
	localparam logic [OP_W-1:0] OP_S_NEXT  = 5'd7;
	localparam logic [OP_W-1:0] OP_VISIT   = 5'd8;
	localparam logic [OP_W-1:0] OP_VISIT2  = 5'd9;
	localparam logic [OP_W-1:0] OP_STEP    = 5'd10;
	localparam logic [OP_W-1:0] OP_EDGE    = 5'd11;
	localparam logic [OP_W-1:0] OP_LOW     = 5'd12;
	localparam logic [OP_W-1:0] OP_POP     = 5'd13;
	localparam logic [OP_W-1:0] OP_CL_RD   = 5'd14;
	localparam logic [OP_W-1:0] OP_CL_POP  = 5'd15;
	localparam logic [OP_W-1:0] OP_PARENT  = 5'd16;
	localparam logic [OP_W-1:0] OP_PAR2    = 5'd17;
	localparam logic [OP_W-1:0] OP_PAR3    = 5'd18;
	localparam logic [OP_W-1:0] OP_O_START = 5'd19;
	localparam logic [OP_W-1:0] OP_O_EMPTY = 5'd20;
	localparam logic [OP_W-1:0] OP_O_RD    = 5'd21;
	localparam logic [OP_W-1:0] OP_O_VT    = 5'd22;
	localparam logic [OP_W-1:0] OP_O_SHOW  = 5'd23;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [SLOT_W-1:0]  slot;
		logic [EPOCH_W-1:0] epoch;
		logic [REQ_W-1:0]   request;
	} vtx_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            load;
	} cmd_t;

	typedef struct packed {
		logic edge_full;
		logic final_q;
		logic lk_end;
		logic fits;
		logic s_end;
		logic s_vis;
		logic cur_ok;
		logic w_vis;
		logic w_onstk;
		logic is_root;
		logic cl_done;
		logic wtop_zero;
		logic emit_zero;
		logic out_last;
	} st_t;

endpackage
`default_nettype wire

// File: hw/rtl/wgcf_ctrl.sv
`default_nettype none
module wgcf_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wgcf_pkg::st_t    st,
	output logic             busy,
	output wgcf_pkg::cmd_t   cmd
);
	import wgcf_pkg::*;

	logic [OP_W-1:0] state_q;
	logic [OP_W-1:0] state_d;

	assign busy = (state_q != OP_IDLE);
	assign cmd.op = state_q;
	assign cmd.load = start && (state_q == OP_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			OP_IDLE: begin
				if (start) state_d = OP_LK_RD;
			end
			OP_LK_RD: begin
				if (st.edge_full) state_d = st.final_q ? OP_S_INIT : OP_IDLE;
				else if (st.lk_end) state_d = OP_ADD_W;
				else state_d = OP_LK_CMP;
			end
			OP_LK_CMP: state_d = OP_LK_RD;
			OP_ADD_W: begin
				if (!st.fits) state_d = st.final_q ? OP_S_INIT : OP_IDLE;
				else state_d = OP_ADD_B;
			end
			OP_ADD_B: state_d = OP_ED_WR;
			OP_ED_WR: state_d = st.final_q ? OP_S_INIT : OP_IDLE;
			OP_S_INIT: state_d = OP_S_NEXT;
			OP_S_NEXT: begin
				if (st.s_end) state_d = OP_O_START;
				else if (!st.s_vis) state_d = OP_VISIT;
			end
			OP_VISIT: state_d = OP_VISIT2;
			OP_VISIT2: state_d = OP_STEP;
			OP_STEP: state_d = st.cur_ok ? OP_EDGE : OP_POP;
			OP_EDGE: begin
				if (!st.w_vis) state_d = OP_VISIT;
				else if (st.w_onstk) state_d = OP_LOW;
				else state_d = OP_STEP;
			end
			OP_LOW: state_d = OP_STEP;
			OP_POP: state_d = st.is_root ? OP_CL_RD : OP_PARENT;
			OP_CL_RD: state_d = OP_CL_POP;
			OP_CL_POP: state_d = st.cl_done ? OP_PARENT : OP_CL_RD;
			OP_PARENT: state_d = st.wtop_zero ? OP_S_NEXT : OP_PAR2;
			OP_PAR2: state_d = OP_PAR3;
			OP_PAR3: state_d = OP_STEP;
			OP_O_START: state_d = st.emit_zero ? OP_O_EMPTY : OP_O_RD;
			OP_O_EMPTY: state_d = OP_IDLE;
			OP_O_RD: state_d = OP_O_VT;
			OP_O_VT: state_d = OP_O_SHOW;
			OP_O_SHOW: state_d = st.out_last ? OP_IDLE : OP_O_RD;
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= OP_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// File: hw/rtl/wgcf_dp.sv
`default_nettype none
module wgcf_dp #(
	parameter int EDGE_SLOTS = 32,
	parameter int MAX_VERTICES = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wgcf_pkg::cmd_t                   cmd,
	output wgcf_pkg::st_t                    st,
	input  wire [wgcf_pkg::NODE_W-1:0]       waiter_node,
	input  wire [wgcf_pkg::SLOT_W-1:0]       waiter_slot,
	input  wire [wgcf_pkg::EPOCH_W-1:0]      waiter_epoch,
	input  wire [wgcf_pkg::REQ_W-1:0]        waiter_request,
	input  wire [wgcf_pkg::NODE_W-1:0]       blocker_node,
	input  wire [wgcf_pkg::SLOT_W-1:0]       blocker_slot,
	input  wire [wgcf_pkg::EPOCH_W-1:0]      blocker_epoch,
	input  wire [wgcf_pkg::REQ_W-1:0]        blocker_request,
	input  wire                              final_edge,
	input  wire                              cfg_valid,
	input  wire [wgcf_pkg::CFG_W-1:0]        cfg_data,
	output logic                             result_strobe,
	output logic                             has_vertex,
	output logic [wgcf_pkg::NODE_W-1:0]      out_node,
	output logic [wgcf_pkg::SLOT_W-1:0]      out_slot,
	output logic [wgcf_pkg::EPOCH_W-1:0]     out_epoch,
	output logic [wgcf_pkg::REQ_W-1:0]       out_request,
	output logic [wgcf_pkg::TOTAL_W-1:0]     cycle_total,
	output logic                             scan_done
);
	import wgcf_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int ECW = $clog2(EDGE_SLOTS + 1);
	localparam int AW = 1 + EW + VW;

	// edge word and lookup results
	vtx_t w_q, b_q;
	logic final_q;
	logic [CW-1:0] vcnt_q, i_q;
	logic [ECW-1:0] ecnt_q;
	logic fw_q, fb_q;
	logic [VW-1:0] wi_q, bi_q;

	// memories
	vtx_t vtab [MAX_VERTICES];
	vtx_t vrd_q;
	logic [EW-1:0] head_mem [MAX_VERTICES];
	logic [EW-1:0] hrd_q;
	logic [AW-1:0] adj_mem [EDGE_SLOTS];
	logic [AW-1:0] ard_q;
	logic [CW-1:0] vo_mem [MAX_VERTICES];
	logic [CW-1:0] vord_q;
	logic [CW-1:0] ll_mem [MAX_VERTICES];
	logic [CW-1:0] llrd_q;
	logic [VW-1:0] comp_mem [MAX_VERTICES];
	logic [VW-1:0] crd_q;
	logic [AW-1:0] walk_mem [MAX_VERTICES];
	logic [AW-1:0] wrd_q;
	logic [VW-1:0] emit_mem [RESULT_CAP];
	logic [VW-1:0] erd_q;

	// per-vertex flags
	logic [MAX_VERTICES-1:0] head_ok_q, self_q, vis_q, onstk_q;

	// walk state
	logic [CW-1:0] num_q, ctop_q, wtop_q, s_q;
	logic [VW-1:0] vis_v_q, cur_v_q, root_q;
	logic [EW-1:0] cur_it_q;
	logic cur_ok_q, first_q, cyc_q;
	logic [CW-1:0] cur_ll_q, cur_vo_q, popll_q;
	logic [EMW-1:0] emcnt_q, k_q;
	logic [TOTAL_W-1:0] cycles_q;
	logic [CFG_W-1:0] cap_q;

	// combinational helpers
	logic same;
	logic [1:0] need;
	logic [CW:0] vneed;
	logic [CW-1:0] ctop_m1, wtop_m1;
	logic [VW-1:0] edge_w, pop_w;
	logic [EW-1:0] edge_nx;
	logic edge_ok;
	logic is_cyc;
	logic [EMW-1:0] capv, k_p1;
	logic [VW-1:0] vaddr, haddr, voaddr;
	logic add_b;

	assign same = (w_q == b_q);
	assign need = {1'b0, !fw_q} + {1'b0, (!fb_q && !(same && !fw_q))};
	assign vneed = {1'b0, vcnt_q} + (CW+1)'(need);
	assign ctop_m1 = ctop_q - CW'(1);
	assign wtop_m1 = wtop_q - CW'(1);
	assign edge_w = ard_q[VW-1:0];
	assign edge_nx = ard_q[VW +: EW];
	assign edge_ok = ard_q[AW-1];
	assign pop_w = crd_q;
	assign is_cyc = first_q ? ((pop_w != root_q) || self_q[root_q]) : cyc_q;
	assign capv = (cap_q > EMW'(RESULT_CAP)) ? EMW'(RESULT_CAP) : cap_q;
	assign k_p1 = k_q + EMW'(1);
	assign add_b = !fb_q && !same;

	always_comb begin
		st.edge_full = (ecnt_q >= ECW'(EDGE_SLOTS));
		st.final_q = final_q;
		st.lk_end = (i_q == vcnt_q);
		st.fits = (vneed <= (CW+1)'(MAX_VERTICES));
		st.s_end = (s_q == vcnt_q);
		st.s_vis = vis_q[s_q[VW-1:0]];
		st.cur_ok = cur_ok_q;
		st.w_vis = vis_q[edge_w];
		st.w_onstk = onstk_q[edge_w];
		st.is_root = (cur_ll_q == cur_vo_q);
		st.cl_done = (pop_w == root_q) || (ctop_q == CW'(1));
		st.wtop_zero = (wtop_q == '0);
		st.emit_zero = (emcnt_q == '0);
		st.out_last = (k_p1 == emcnt_q);
	end

	// read address selection
	assign vaddr = (cmd.op == OP_O_VT) ? erd_q : i_q[VW-1:0];
	assign haddr = (cmd.op == OP_VISIT) ? vis_v_q : wi_q;
	assign voaddr = (cmd.op == OP_PAR2) ? wrd_q[VW-1:0] : edge_w;

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ADD_W && st.fits && !fw_q) vtab[vcnt_q[VW-1:0]] <= w_q;
		if (cmd.op == OP_ADD_B && add_b) vtab[vcnt_q[VW-1:0]] <= b_q;
		vrd_q <= vtab[vaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ED_WR) head_mem[wi_q] <= ecnt_q[EW-1:0];
		hrd_q <= head_mem[haddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ED_WR) adj_mem[ecnt_q[EW-1:0]] <= {head_ok_q[wi_q], hrd_q, bi_q};
		ard_q <= adj_mem[cur_it_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_VISIT2) vo_mem[vis_v_q] <= num_q;
		vord_q <= vo_mem[voaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_VISIT && wtop_q != '0) ll_mem[cur_v_q] <= cur_ll_q;
		llrd_q <= ll_mem[wrd_q[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_VISIT2) comp_mem[ctop_q[VW-1:0]] <= vis_v_q;
		crd_q <= comp_mem[ctop_m1[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_VISIT && wtop_q != '0)
			walk_mem[wtop_m1[VW-1:0]] <= {cur_ok_q, cur_it_q, cur_v_q};
		wrd_q <= walk_mem[wtop_m1[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CL_POP && is_cyc && emcnt_q < capv) emit_mem[emcnt_q[EIW-1:0]] <= pop_w;
		erd_q <= emit_mem[k_q[EIW-1:0]];
	end

	// edge word latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= '{waiter_node, waiter_slot, waiter_epoch, waiter_request};
			b_q <= '{blocker_node, blocker_slot, blocker_epoch, blocker_request};
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LK_CMP: begin
				if (vrd_q == w_q && !fw_q) wi_q <= i_q[VW-1:0];
				if (vrd_q == b_q && !fb_q) bi_q <= i_q[VW-1:0];
			end
			OP_ADD_W: begin
				if (!fw_q) wi_q <= vcnt_q[VW-1:0];
			end
			OP_ADD_B: begin
				if (!fb_q && same) bi_q <= wi_q;
				else if (add_b) bi_q <= vcnt_q[VW-1:0];
			end
			OP_S_NEXT: vis_v_q <= s_q[VW-1:0];
			OP_VISIT2: begin
				cur_v_q <= vis_v_q;
				cur_it_q <= hrd_q;
				cur_ok_q <= head_ok_q[vis_v_q];
				cur_ll_q <= num_q;
				cur_vo_q <= num_q;
			end
			OP_EDGE: begin
				cur_it_q <= edge_nx;
				cur_ok_q <= edge_ok;
				vis_v_q <= edge_w;
			end
			OP_LOW: begin
				if (vord_q < cur_ll_q) cur_ll_q <= vord_q;
			end
			OP_POP: begin
				popll_q <= cur_ll_q;
				root_q <= cur_v_q;
			end
			OP_PAR2: begin
				cur_v_q <= wrd_q[VW-1:0];
				cur_it_q <= wrd_q[VW +: EW];
				cur_ok_q <= wrd_q[AW-1];
			end
			OP_PAR3: begin
				cur_ll_q <= (llrd_q < popll_q) ? llrd_q : popll_q;
				cur_vo_q <= vord_q;
			end
			default: begin
			end
		endcase
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q <= 1'b0;
			vcnt_q <= '0;
			ecnt_q <= '0;
			i_q <= '0;
			fw_q <= 1'b0;
			fb_q <= 1'b0;
			head_ok_q <= '0;
			self_q <= '0;
			vis_q <= '0;
			onstk_q <= '0;
			num_q <= '0;
			ctop_q <= '0;
			wtop_q <= '0;
			s_q <= '0;
			first_q <= 1'b0;
			cyc_q <= 1'b0;
			emcnt_q <= '0;
			k_q <= '0;
			cycles_q <= '0;
			cap_q <= CFG_W'(RESULT_CAP);
			result_strobe <= 1'b0;
			has_vertex <= 1'b0;
			out_node <= '0;
			out_slot <= '0;
			out_epoch <= '0;
			out_request <= '0;
			cycle_total <= '0;
			scan_done <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_valid) cap_q <= cfg_data;
			if (cmd.load) begin
				final_q <= final_edge;
				i_q <= '0;
				fw_q <= 1'b0;
				fb_q <= 1'b0;
			end
			case (cmd.op)
				OP_LK_CMP: begin
					if (vrd_q == w_q) fw_q <= 1'b1;
					if (vrd_q == b_q) fb_q <= 1'b1;
					i_q <= i_q + CW'(1);
				end
				OP_ADD_W: begin
					if (st.fits && !fw_q) begin
						head_ok_q[vcnt_q[VW-1:0]] <= 1'b0;
						self_q[vcnt_q[VW-1:0]] <= 1'b0;
						vcnt_q <= vcnt_q + CW'(1);
					end
				end
				OP_ADD_B: begin
					if (add_b) begin
						head_ok_q[vcnt_q[VW-1:0]] <= 1'b0;
						self_q[vcnt_q[VW-1:0]] <= 1'b0;
						vcnt_q <= vcnt_q + CW'(1);
					end
				end
				OP_ED_WR: begin
					head_ok_q[wi_q] <= 1'b1;
					if (wi_q == bi_q) self_q[wi_q] <= 1'b1;
					ecnt_q <= ecnt_q + ECW'(1);
				end
				OP_S_INIT: begin
					vis_q <= '0;
					onstk_q <= '0;
					num_q <= '0;
					ctop_q <= '0;
					s_q <= '0;
					emcnt_q <= '0;
					cycles_q <= '0;
				end
				OP_S_NEXT: begin
					if (!st.s_end) begin
						if (st.s_vis) s_q <= s_q + CW'(1);
						else wtop_q <= '0;
					end
				end
				OP_VISIT2: begin
					num_q <= num_q + CW'(1);
					vis_q[vis_v_q] <= 1'b1;
					onstk_q[vis_v_q] <= 1'b1;
					ctop_q <= ctop_q + CW'(1);
					wtop_q <= wtop_q + CW'(1);
				end
				OP_POP: begin
					wtop_q <= wtop_m1;
					first_q <= 1'b1;
				end
				OP_CL_POP: begin
					onstk_q[pop_w] <= 1'b0;
					ctop_q <= ctop_m1;
					first_q <= 1'b0;
					cyc_q <= is_cyc;
					if (first_q && is_cyc && cycles_q != '1) cycles_q <= cycles_q + TOTAL_W'(1);
					if (is_cyc && emcnt_q < capv) emcnt_q <= emcnt_q + EMW'(1);
				end
				OP_PARENT: begin
					if (wtop_q == '0) s_q <= s_q + CW'(1);
				end
				OP_O_START: k_q <= '0;
				OP_O_EMPTY: begin
					result_strobe <= 1'b1;
					has_vertex <= 1'b0;
					out_node <= '0;
					out_slot <= '0;
					out_epoch <= '0;
					out_request <= '0;
					cycle_total <= cycles_q;
					scan_done <= 1'b1;
					vcnt_q <= '0;
					ecnt_q <= '0;
				end
				OP_O_SHOW: begin
					result_strobe <= 1'b1;
					has_vertex <= 1'b1;
					out_node <= vrd_q.node;
					out_slot <= vrd_q.slot;
					out_epoch <= vrd_q.epoch;
					out_request <= vrd_q.request;
					cycle_total <= st.out_last ? cycles_q : '0;
					scan_done <= st.out_last;
					k_q <= k_p1;
					if (st.out_last) begin
						vcnt_q <= '0;
						ecnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/wait_graph_cycle_finder_core.sv
// channel   direction  handshake                       payload
// edge      in         start & !busy                   waiter_*, blocker_*, final_edge
// result    out        result_strobe (no backpressure) has_vertex, out_*, cycle_total, scan_done
// config    in         cfg_valid & cfg_ready           cfg_data (max_out_vertices)
//
// A stored edge keeps busy high while one vertex table read port serves the serial lookup
// of both endpoints, entry by entry over the V vertices stored so far.
// The final edge then runs the search over every vertex and edge, then sends each
// emitted vertex out through the emit buffer.
// Reset clears all counters and flags at once; no clearing pass is needed.
// Results appear one per strobe and cannot be held off; busy stays high until the last.
`default_nettype none
module wait_graph_cycle_finder_core #(
	parameter int EDGE_SLOTS = 32,
	parameter int MAX_VERTICES = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire [wgcf_pkg::NODE_W-1:0]       waiter_node,
	input  wire [wgcf_pkg::SLOT_W-1:0]       waiter_slot,
	input  wire [wgcf_pkg::EPOCH_W-1:0]      waiter_epoch,
	input  wire [wgcf_pkg::REQ_W-1:0]        waiter_request,
	input  wire [wgcf_pkg::NODE_W-1:0]       blocker_node,
	input  wire [wgcf_pkg::SLOT_W-1:0]       blocker_slot,
	input  wire [wgcf_pkg::EPOCH_W-1:0]      blocker_epoch,
	input  wire [wgcf_pkg::REQ_W-1:0]        blocker_request,
	input  wire                              final_edge,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [wgcf_pkg::CFG_W-1:0]        cfg_data,
	output logic                             result_strobe,
	output logic                             has_vertex,
	output logic [wgcf_pkg::NODE_W-1:0]      out_node,
	output logic [wgcf_pkg::SLOT_W-1:0]      out_slot,
	output logic [wgcf_pkg::EPOCH_W-1:0]     out_epoch,
	output logic [wgcf_pkg::REQ_W-1:0]       out_request,
	output logic [wgcf_pkg::TOTAL_W-1:0]     cycle_total,
	output logic                             scan_done
);
	import wgcf_pkg::*;

	cmd_t cmd;
	st_t st;

	assign cfg_ready = 1'b1;

	wgcf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	wgcf_dp #(
		.EDGE_SLOTS   (EDGE_SLOTS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.waiter_node     (waiter_node),
		.waiter_slot     (waiter_slot),
		.waiter_epoch    (waiter_epoch),
		.waiter_request  (waiter_request),
		.blocker_node    (blocker_node),
		.blocker_slot    (blocker_slot),
		.blocker_epoch   (blocker_epoch),
		.blocker_request (blocker_request),
		.final_edge      (final_edge),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.result_strobe   (result_strobe),
		.has_vertex      (has_vertex),
		.out_node        (out_node),
		.out_slot        (out_slot),
		.out_epoch       (out_epoch),
		.out_request     (out_request),
		.cycle_total     (cycle_total),
		.scan_done       (scan_done)
	);

endmodule
`default_nettype wire

// File: hw/rtl/wgcf_checker.sv
`default_nettype none
`include "wait_graph_cycle_finder_core_macros.svh"
module wgcf_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              start,
	input wire                              busy,
	input wire                              result_strobe,
	input wire                              has_vertex,
	input wire [wgcf_pkg::NODE_W-1:0]       out_node,
	input wire [wgcf_pkg::SLOT_W-1:0]       out_slot,
	input wire [wgcf_pkg::TOTAL_W-1:0]      cycle_total,
	input wire                              scan_done
);
	// an accepted word always makes the block busy
	`WGCF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	// an empty scan result is always the last one and carries no identity
	`WGCF_ASSERT_NOW(a_empty_last, result_strobe && !has_vertex, scan_done && out_node == '0 && out_slot == '0, "empty result malformed")
	// more results pending keeps the block busy
	`WGCF_ASSERT_NEXT(a_more_busy, result_strobe && !scan_done, busy, "busy dropped mid scan")
	// cycle count shows only on the last word
	`WGCF_ASSERT_NOW(a_total_last, result_strobe && !scan_done, cycle_total == '0, "total on non-final word")
endmodule

bind wait_graph_cycle_finder_core wgcf_checker u_wgcf_checker (.*);
`default_nettype wire
